// ----- sv/per_cpu_page_allocator_top_defines.svh -----
// Assertion macros for the per-processor page allocator
`ifndef PER_CPU_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define PER_CPU_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Check that prop holds at every clock edge outside reset
`define PCPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cond never holds outside reset
`define PCPA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/pcpa_pkg.sv -----
// Shared types, widths and codes of the per-processor page allocator
`timescale 1ns / 1ps
package pcpa_pkg;

    localparam int NUM_CPUS_DEF  = 8;
    localparam int NUM_PAGES_DEF = 32768;

    localparam int ADDR_W   = 34;
    localparam int HIGH_W   = 35;
    localparam int PG_SHIFT = 12;
    localparam int PGSIZE   = 4096;
    localparam int BASE_W   = HIGH_W - PG_SHIFT;
    localparam int CPU_ID_W = 3;
    localparam int STAT_W   = 2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD = 2'd2;

    localparam logic REG_MEM_LOW  = 1'b0;
    localparam logic REG_MEM_HIGH = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE,
        S_ALLOC
    } state_t;

endpackage

// ----- sv/pcpa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read
`timescale 1ns / 1ps
module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/pcpa_free_chk.sv -----
// Free address check and page index computation
`timescale 1ns / 1ps
module pcpa_free_chk
    import pcpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic [ADDR_W-1:0]            free_addr,
    input  logic [ADDR_W-1:0]            mem_low,
    input  logic [HIGH_W-1:0]            mem_high,
    input  logic [BASE_W-1:0]            base,
    output logic                         ok,
    output logic [$clog2(NUM_PAGES)-1:0] idx
);

    localparam int PW = $clog2(NUM_PAGES);

    logic              aligned;
    logic              above_low;
    logic              below_high;
    logic              above_base;
    logic              in_range;
    logic [BASE_W-1:0] pg;
    logic [BASE_W-1:0] diff;

    always_comb
    begin
        aligned    = (free_addr[PG_SHIFT-1:0] == '0);
        above_low  = (free_addr >= mem_low);
        below_high = ({1'b0, free_addr} < mem_high);
        pg         = {1'b0, free_addr[ADDR_W-1:PG_SHIFT]};
        above_base = (pg >= base);
        diff       = pg - base;
        in_range   = (diff < BASE_W'(NUM_PAGES));
        ok         = aligned && above_low && below_high && above_base && in_range;
        idx        = diff[PW-1:0];
    end

endmodule

// ----- sv/per_cpu_page_allocator_top.sv -----
// Top level of the per-processor page allocator with stealing
// done pulses for one cycle; a taken start moves state_reg into S_FREE or S_ALLOC, and done_reg is set from there.
// A new start is not taken while busy; the link memory read, then write-back of the list head,
// sets this. busy is high while state_reg is in S_FREE or S_ALLOC.
// Reset: all free lists empty, both bounds zero; the link memory is not cleared.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module per_cpu_page_allocator_top
    import pcpa_pkg::*;
#(
    parameter int NUM_CPUS  = NUM_CPUS_DEF,
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [HIGH_W-1:0]   cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  logic                req_type,
    input  logic [CPU_ID_W-1:0] cpu_id,
    input  logic [ADDR_W-1:0]   free_addr,
    output logic                done,
    output logic [ADDR_W-1:0]   page_addr,
    output logic [STAT_W-1:0]   status
);

`include "per_cpu_page_allocator_top_defines.svh"

    localparam int PW = $clog2(NUM_PAGES);
    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] mem_low_reg;
    logic [HIGH_W-1:0] mem_high_reg;
    logic [BASE_W-1:0] base_reg;
    logic [HIGH_W-1:0] low_sum;

    logic [NUM_CPUS-1:0] head_vld_reg, head_vld_next;
    logic [PW-1:0]       head_idx_reg [NUM_CPUS];
    logic [PW-1:0]       head_idx_next [NUM_CPUS];

    logic [CW-1:0]     sel_reg, sel_next;
    logic              found_reg, found_next;
    logic [PW-1:0]     pop_idx_reg, pop_idx_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic              done_reg, done_next;
    logic [ADDR_W-1:0] page_addr_reg, page_addr_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic [CPU_ID_W-1:0] cpu_r;
    logic [CW-1:0]       cpu_m;
    logic [CW-1:0]       first;
    logic [CW-1:0]       rd_sel;
    logic [PW-1:0]       rd_idx;
    logic                rd_vld;
    logic                accept;

    logic          link_we;
    logic [PW-1:0] link_waddr;
    logic [PW:0]   link_wdata;
    logic [PW:0]   link_rdata;

    logic              chk_ok;
    logic [PW-1:0]     chk_idx;
    logic [BASE_W-1:0] page_sum;

    pcpa_free_chk #(
        .NUM_PAGES(NUM_PAGES)
    ) u_free_chk (
        .free_addr(addr_reg),
        .mem_low  (mem_low_reg),
        .mem_high (mem_high_reg),
        .base     (base_reg),
        .ok       (chk_ok),
        .idx      (chk_idx)
    );

    pcpa_ram #(
        .WIDTH(PW + 1),
        .DEPTH(NUM_PAGES)
    ) u_link_ram (
        .clk  (clk),
        .we   (link_we),
        .waddr(link_waddr),
        .wdata(link_wdata),
        .raddr(rd_idx),
        .rdata(link_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign page_addr = page_addr_reg;
    assign status    = status_reg;

    // fold cpu_id onto the configured number of lists
    always_comb
    begin
        cpu_r = cpu_id;
        for (int k = 0; k < (1 << CPU_ID_W); k++)
        begin
            if (int'(cpu_r) >= NUM_CPUS)
            begin
                cpu_r = cpu_r - CPU_ID_W'(NUM_CPUS);
            end
        end
        cpu_m = CW'(cpu_r);
    end

    always_comb
    begin
        first = '0;
        for (int c = NUM_CPUS - 1; c >= 0; c--)
        begin
            if (head_vld_reg[c])
            begin
                first = CW'(c);
            end
        end
    end

    always_comb
    begin
        low_sum = {1'b0, cfg_wdata[ADDR_W-1:0]} + HIGH_W'(PGSIZE - 1);
    end

    always_comb
    begin
        state_next     = state_reg;
        head_vld_next  = head_vld_reg;
        head_idx_next  = head_idx_reg;
        sel_next       = sel_reg;
        found_next     = found_reg;
        pop_idx_next   = pop_idx_reg;
        addr_next      = addr_reg;
        done_next      = 1'b0;
        page_addr_next = page_addr_reg;
        status_next    = status_reg;
        link_we        = 1'b0;
        link_waddr     = chk_idx;
        page_sum       = base_reg + BASE_W'(pop_idx_reg);

        rd_sel = head_vld_reg[cpu_m] ? cpu_m : first;
        if (state_reg == S_FREE)
        begin
            rd_sel = sel_reg;
        end
        rd_idx     = head_idx_reg[rd_sel];
        rd_vld     = head_vld_reg[rd_sel];
        link_wdata = {rd_vld, rd_idx};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_next    = free_addr;
                    pop_idx_next = rd_idx;
                    if (req_type == REQ_FREE)
                    begin
                        sel_next   = cpu_m;
                        state_next = S_FREE;
                    end
                    else
                    begin
                        sel_next   = rd_sel;
                        found_next = |head_vld_reg;
                        state_next = S_ALLOC;
                    end
                end
            end
            S_FREE:
            begin
                // push onto the requester's list
                if (chk_ok)
                begin
                    link_we                = 1'b1;
                    head_idx_next[sel_reg] = chk_idx;
                    head_vld_next[sel_reg] = 1'b1;
                    status_next            = STAT_OK;
                end
                else
                begin
                    status_next = STAT_BAD;
                end
                page_addr_next = '0;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            S_ALLOC:
            begin
                // pop: follow the link read at accept time
                if (found_reg)
                begin
                    head_idx_next[sel_reg] = link_rdata[PW-1:0];
                    head_vld_next[sel_reg] = link_rdata[PW];
                    page_addr_next = {page_sum[ADDR_W-PG_SHIFT-1:0], {PG_SHIFT{1'b0}}};
                    status_next    = STAT_OK;
                end
                else
                begin
                    page_addr_next = '0;
                    status_next    = STAT_OOM;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_vld_reg <= '0;
            done_reg     <= 1'b0;
            mem_low_reg  <= '0;
            mem_high_reg <= '0;
            base_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_vld_reg <= head_vld_next;
            done_reg     <= done_next;
            if (cfg_we && (cfg_index == REG_MEM_LOW))
            begin
                mem_low_reg <= cfg_wdata[ADDR_W-1:0];
                base_reg    <= low_sum[HIGH_W-1:PG_SHIFT];
            end
            if (cfg_we && (cfg_index == REG_MEM_HIGH))
            begin
                mem_high_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_idx_reg  <= head_idx_next;
        sel_reg       <= sel_next;
        found_reg     <= found_next;
        pop_idx_reg   <= pop_idx_next;
        addr_reg      <= addr_next;
        page_addr_reg <= page_addr_next;
        status_reg    <= status_next;
    end

    `PCPA_ASSERT(a_accept_busy, accept |=> busy, "start taken but busy not raised")
    `PCPA_ASSERT(a_done_after_work, done |-> $past(busy), "done without a request at work")
    `PCPA_ASSERT(a_zero_addr, (done && (status != STAT_OK)) |-> (page_addr == '0), "page address not zero on failure")
    `PCPA_NEVER(a_link_wr_state, link_we && (state_reg != S_FREE), "link write outside free")
    `PCPA_ASSERT(a_push_valid, (state_reg == S_FREE) && chk_ok |=> head_vld_reg[$past(sel_reg)], "pushed list still empty")

endmodule
